/* sv/hobd_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the framed hex / base64 string decoder
package hobd_pkg;

    localparam int LEN_W = 32;

    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_ERR  = 1'b1;

    localparam logic [1:0] ERR_TYPE_CHAR = 2'd0;
    localparam logic [1:0] ERR_UNSUP     = 2'd1;
    localparam logic [1:0] ERR_BODY      = 2'd2;
    localparam logic [1:0] ERR_ZERO_LEN  = 2'd3;

    localparam logic [7:0] TYPE_HEX    = 8'h01;
    localparam logic [7:0] TYPE_BASE64 = 8'h02;

    localparam logic [3:0] HDR_SKIP  = 4'd5;
    localparam logic [3:0] HDR_TOTAL = 4'd9;

    typedef enum logic [3:0] {
        PH_TYPE    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_HALT    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       is_nul;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       sym_ok;
        logic [5:0] sym_val;
    } cls_t;

endpackage

/* sv/hobd_char_if.sv */
`timescale 1ns / 1ps
// character input channel
interface hobd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink (input valid, input character, output ready);
endinterface

/* sv/hobd_res_if.sv */
`timescale 1ns / 1ps
// decoded result channel
interface hobd_res_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [1:0] error_code;

    modport source (output valid, output out_kind, output data_byte, output last_byte,
                    output error_code, input ready);
    modport sink (input valid, input out_kind, input data_byte, input last_byte,
                  input error_code, output ready);
endinterface

/* sv/hobd_front.sv */
`timescale 1ns / 1ps
// front end: accepts characters and classifies them for the queue
module hobd_front (
    hobd_char_if.sink     chars,
    output logic          push_valid,
    output hobd_pkg::cls_t push_data,
    input  logic          push_ready
);

    logic [7:0] c;

    assign c = chars.character;

    always_comb
    begin
        push_data = '0;
        push_data.is_nul = (c == 8'h00);

        if (c inside {[8'h30:8'h39]})
        begin
            push_data.hex_ok  = 1'b1;
            push_data.hex_val = 4'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            push_data.hex_ok  = 1'b1;
            push_data.hex_val = 4'(c - 8'h37);
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            push_data.hex_ok  = 1'b1;
            push_data.hex_val = 4'(c - 8'h57);
        end

        if (c inside {[8'h30:8'h39]})
        begin
            push_data.sym_ok  = 1'b1;
            push_data.sym_val = 6'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h5A]})
        begin
            push_data.sym_ok  = 1'b1;
            push_data.sym_val = 6'(c - 8'h41 + 8'd10);
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            push_data.sym_ok  = 1'b1;
            push_data.sym_val = 6'(c - 8'h61 + 8'd36);
        end
        else if (c == 8'h7B)
        begin
            push_data.sym_ok  = 1'b1;
            push_data.sym_val = 6'd62;
        end
        else if (c == 8'h7D)
        begin
            push_data.sym_ok  = 1'b1;
            push_data.sym_val = 6'd63;
        end
    end

    assign push_valid  = chars.valid;
    assign chars.ready = push_ready;

endmodule

/* sv/hobd_fifo.sv */
`timescale 1ns / 1ps
// two-entry queue between front and back end
module hobd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  hobd_pkg::cls_t push_data,
    output logic           push_ready,
    output logic           pop_valid,
    output hobd_pkg::cls_t pop_data,
    input  logic           pop_ready
);

    hobd_pkg::cls_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/hobd_back.sv */
`timescale 1ns / 1ps
// back end: frame decoding state machine and output register
module hobd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    input  hobd_pkg::cls_t pop_data,
    output logic           pop_ready,
    hobd_res_if.source     results
);

    hobd_pkg::phase_t          phase_reg;
    hobd_pkg::phase_t          phase_next;
    logic                      b64_reg;
    logic                      b64_next;
    logic [3:0]                hi_nib_reg;
    logic [3:0]                hi_nib_next;
    logic                      second_reg;
    logic                      second_next;
    logic [1:0]                sext_pos_reg;
    logic [1:0]                sext_pos_next;
    logic [7:0]                carry_reg;
    logic [7:0]                carry_next;
    logic [3:0]                hdr_cnt_reg;
    logic [3:0]                hdr_cnt_next;
    logic [31:0]               len_reg;
    logic [31:0]               len_next;
    logic [hobd_pkg::LEN_W-1:0] rem_reg;
    logic [hobd_pkg::LEN_W-1:0] rem_next;

    logic                      ov_reg;
    logic                      ov_next;
    logic                      kind_reg;
    logic                      kind_next;
    logic [7:0]                byte_reg;
    logic [7:0]                byte_next;
    logic                      last_reg;
    logic                      last_next;
    logic [1:0]                code_reg;
    logic [1:0]                code_next;

    logic                      pop;
    logic                      body_ok;
    logic                      have_byte;
    logic [7:0]                b;
    logic [7:0]                type_val;
    logic [3:0]                cnt_inc;
    logic [31:0]               len_new;
    logic [hobd_pkg::LEN_W-1:0] rem_dec;
    logic [5:0]                v;

    assign pop_ready = !ov_reg || results.ready;
    assign pop       = pop_valid && pop_ready;
    assign v         = pop_data.sym_val;
    assign type_val  = {hi_nib_reg, pop_data.hex_val};
    assign cnt_inc   = hdr_cnt_reg + 4'd1;
    assign rem_dec   = rem_reg - {{(hobd_pkg::LEN_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        phase_next    = phase_reg;
        b64_next      = b64_reg;
        hi_nib_next   = hi_nib_reg;
        second_next   = second_reg;
        sext_pos_next = sext_pos_reg;
        carry_next    = carry_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        len_next      = len_reg;
        rem_next      = rem_reg;
        ov_next       = ov_reg && !results.ready;
        kind_next     = kind_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        code_next     = code_reg;
        have_byte     = 1'b0;
        b             = 8'h00;
        body_ok       = b64_reg ? pop_data.sym_ok : pop_data.hex_ok;
        len_new       = {len_reg[23:0], 8'h00};

        // body character to byte
        if (!b64_reg)
        begin
            if (!second_reg)
            begin
                hi_nib_next = pop_data.hex_val;
                second_next = 1'b1;
            end
            else
            begin
                second_next = 1'b0;
                have_byte   = 1'b1;
                b           = {hi_nib_reg, pop_data.hex_val};
            end
        end
        else
        begin
            case (sext_pos_reg)
                2'd0:
                begin
                    carry_next    = {v, 2'b00};
                    sext_pos_next = 2'd1;
                end
                2'd1:
                begin
                    have_byte     = 1'b1;
                    b             = carry_reg | {6'b0, v[5:4]};
                    carry_next    = {v[3:0], 4'b0};
                    sext_pos_next = 2'd2;
                end
                2'd2:
                begin
                    have_byte     = 1'b1;
                    b             = carry_reg | {4'b0, v[5:2]};
                    carry_next    = {v[1:0], 6'b0};
                    sext_pos_next = 2'd3;
                end
                default:
                begin
                    have_byte     = 1'b1;
                    b             = carry_reg | {2'b0, v};
                    carry_next    = 8'h00;
                    sext_pos_next = 2'd0;
                end
            endcase
        end
        len_new = (hdr_cnt_reg >= hobd_pkg::HDR_SKIP) ? {len_reg[23:0], b} : len_reg;

        if (pop)
        begin
            ov_next   = 1'b0;
            kind_next = hobd_pkg::KIND_ERR;
            byte_next = 8'h00;
            last_next = 1'b0;
            code_next = hobd_pkg::ERR_TYPE_CHAR;

            if (pop_data.is_nul)
            begin
                ov_next       = (phase_reg != hobd_pkg::PH_HALT);
                code_next     = (phase_reg == hobd_pkg::PH_TYPE) ? hobd_pkg::ERR_TYPE_CHAR
                                                                 : hobd_pkg::ERR_BODY;
                phase_next    = hobd_pkg::PH_TYPE;
                b64_next      = 1'b0;
                hi_nib_next   = 4'd0;
                second_next   = 1'b0;
                sext_pos_next = 2'd0;
                carry_next    = 8'h00;
                hdr_cnt_next  = 4'd0;
                len_next      = 32'd0;
                rem_next      = '0;
            end
            else
            begin
                case (phase_reg)
                    hobd_pkg::PH_TYPE:
                    begin
                        sext_pos_next = sext_pos_reg;
                        carry_next    = carry_reg;
                        if (!pop_data.hex_ok)
                        begin
                            hi_nib_next = hi_nib_reg;
                            second_next = second_reg;
                            phase_next  = hobd_pkg::PH_HALT;
                            ov_next     = 1'b1;
                            code_next   = hobd_pkg::ERR_TYPE_CHAR;
                        end
                        else if (!second_reg)
                        begin
                            hi_nib_next = pop_data.hex_val;
                            second_next = 1'b1;
                        end
                        else
                        begin
                            second_next = 1'b0;
                            hi_nib_next = 4'd0;
                            if (type_val != hobd_pkg::TYPE_HEX &&
                                type_val != hobd_pkg::TYPE_BASE64)
                            begin
                                phase_next = hobd_pkg::PH_HALT;
                                ov_next    = 1'b1;
                                code_next  = hobd_pkg::ERR_UNSUP;
                            end
                            else
                            begin
                                b64_next     = (type_val == hobd_pkg::TYPE_BASE64);
                                phase_next   = hobd_pkg::PH_HEADER;
                                hdr_cnt_next = 4'd0;
                            end
                        end
                    end
                    hobd_pkg::PH_HEADER,
                    hobd_pkg::PH_PAYLOAD:
                    begin
                        if (!body_ok)
                        begin
                            hi_nib_next   = hi_nib_reg;
                            second_next   = second_reg;
                            sext_pos_next = sext_pos_reg;
                            carry_next    = carry_reg;
                            phase_next    = hobd_pkg::PH_HALT;
                            ov_next       = 1'b1;
                            code_next     = hobd_pkg::ERR_BODY;
                        end
                        else if (have_byte && phase_reg == hobd_pkg::PH_HEADER)
                        begin
                            len_next     = len_new;
                            hdr_cnt_next = cnt_inc;
                            if (cnt_inc >= hobd_pkg::HDR_TOTAL)
                            begin
                                if (len_new == 32'd0)
                                begin
                                    phase_next = hobd_pkg::PH_HALT;
                                    ov_next    = 1'b1;
                                    code_next  = hobd_pkg::ERR_ZERO_LEN;
                                end
                                else
                                begin
                                    // saturate when the length exceeds the counter
                                    rem_next   = ((len_new >> hobd_pkg::LEN_W) != 32'd0)
                                                 ? '1 : len_new[hobd_pkg::LEN_W-1:0];
                                    phase_next = hobd_pkg::PH_PAYLOAD;
                                end
                            end
                        end
                        else if (have_byte)
                        begin
                            rem_next  = rem_dec;
                            ov_next   = 1'b1;
                            kind_next = hobd_pkg::KIND_BYTE;
                            byte_next = b;
                            last_next = (rem_dec == '0);
                            if (rem_dec == '0)
                            begin
                                phase_next = hobd_pkg::PH_HALT;
                            end
                        end
                    end
                    default:
                    begin
                        hi_nib_next   = hi_nib_reg;
                        second_next   = second_reg;
                        sext_pos_next = sext_pos_reg;
                        carry_next    = carry_reg;
                    end
                endcase
            end
        end
        else
        begin
            hi_nib_next   = hi_nib_reg;
            second_next   = second_reg;
            sext_pos_next = sext_pos_reg;
            carry_next    = carry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= hobd_pkg::PH_TYPE;
            b64_reg      <= 1'b0;
            hi_nib_reg   <= 4'd0;
            second_reg   <= 1'b0;
            sext_pos_reg <= 2'd0;
            carry_reg    <= 8'h00;
            hdr_cnt_reg  <= 4'd0;
            len_reg      <= 32'd0;
            rem_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            b64_reg      <= b64_next;
            hi_nib_reg   <= hi_nib_next;
            second_reg   <= second_next;
            sext_pos_reg <= sext_pos_next;
            carry_reg    <= carry_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            len_reg      <= len_next;
            rem_reg      <= rem_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        code_reg <= code_next;
    end

    assign results.valid      = ov_reg;
    assign results.out_kind   = kind_reg;
    assign results.data_byte  = byte_reg;
    assign results.last_byte  = last_reg;
    assign results.error_code = code_reg;

endmodule

/* sv/hex_or_base64_framed_string_decoder.sv */
`timescale 1ns / 1ps
// top level of the framed hex / base64 string decoder
//
// chars carries one character per word; a NUL word ends the string and rearms
// the decoder. results carries one word per decoded payload byte or per error.
// the first two characters give a hex type byte (1 hex body, 2 base64 body),
// five body bytes are skipped, a big-endian 32-bit length follows, then the
// payload bytes, the final one marked with last_byte.
// throughput: one character per cycle while results is ready, with no bubbles.
// a character passes through a queue entry and then the output register; its
// result word is valid in the cycle after the edge that pops the character
// from the two-entry queue.
// when results stalls, the output register holds its word, the queue fills,
// and chars.ready drops once both queue entries are taken.
// reset clears the queue, the output valid flag and the decoder state; the
// block then expects a type byte.
module hex_or_base64_framed_string_decoder (
    input  logic        clk,
    input  logic        rst_n,
    hobd_char_if.sink   chars,
    hobd_res_if.source  results
);

    logic           push_valid;
    hobd_pkg::cls_t push_data;
    logic           push_ready;
    logic           pop_valid;
    hobd_pkg::cls_t pop_data;
    logic           pop_ready;

    hobd_front u_front (
        .chars      (chars),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    hobd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    hobd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .results   (results)
    );

endmodule
